// ----- sv/vertex_rotate_project_viewport_defines.svh -----
// Assertion macros for the vertex transform pipeline.
// No dependencies.
`ifndef VERTEX_ROTATE_PROJECT_VIEWPORT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_VIEWPORT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VRP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VRP_ASSERT(label, clk, rst_n, prop, msg)
`define VRP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/vrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the vertex transform pipeline.
// No dependencies.
package vrp_pkg;
	localparam int NDC_FRAC = 16;
	localparam int NUM_W    = 74;
	localparam int DEN_W    = 36;
	localparam int QUO_W    = 74;
	// trig registers are Q1.14; the rotation widths below are sized for it
	localparam int TRIG_FRAC_BITS = 14;

	typedef enum logic [2:0] {
		REG_COS_ROLL   = 3'd0,
		REG_SIN_ROLL   = 3'd1,
		REG_COS_PITCH  = 3'd2,
		REG_SIN_PITCH  = 3'd3,
		REG_GAIN_H     = 3'd4,
		REG_GAIN_V     = 3'd5,
		REG_SCREEN_W   = 3'd6,
		REG_SCREEN_H   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] cos_roll;
		logic signed [15:0] sin_roll;
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic [23:0]        gain_h;
		logic [23:0]        gain_v;
		logic [12:0]        screen_w;
		logic [12:0]        screen_h;
	} cfg_t;
endpackage

// ----- sv/vrp_divider.sv -----
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage, truncating quotient.
// Depends on vrp_pkg.
module vrp_divider import vrp_pkg::*; #(
	parameter int NW = 74,
	parameter int DW = 36,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [SW-1:0]        side_in,
	output logic                 out_valid,
	output logic signed [NW-1:0] quo,
	output logic [SW-1:0]        side_out
);
	// divide magnitudes; den == 0 gives a meaningless quotient (caller ignores it)
	logic [NW-1:0] q_s   [1:NW];
	logic [NW-1:0] r_s   [1:NW];
	logic [DW-1:0] d_s   [1:NW];
	logic          neg_s [1:NW];
	logic          v_s   [1:NW];
	logic [SW-1:0] sd_s  [1:NW];
	logic [NW-1:0] q_0;
	logic [DW-1:0] d_0;
	logic          neg_0;

	assign q_0   = num[NW-1] ? NW'(-num) : NW'(num);
	assign d_0   = den[DW-1] ? DW'(-den) : DW'(den);
	assign neg_0 = num[NW-1] ^ den[DW-1];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [NW-1:0] q_i, r_i;
		logic [DW-1:0] d_i;
		logic          neg_i, v_i;
		logic [SW-1:0] sd_i;
		logic [NW:0]   rem_sh;
		logic [NW:0]   diff;
		logic [NW-1:0] q_n, r_n;
		if (g == 0) begin : g_head
			assign q_i   = q_0;
			assign r_i   = '0;
			assign d_i   = d_0;
			assign neg_i = neg_0;
			assign v_i   = in_valid;
			assign sd_i  = side_in;
		end else begin : g_body
			assign q_i   = q_s[g];
			assign r_i   = r_s[g];
			assign d_i   = d_s[g];
			assign neg_i = neg_s[g];
			assign v_i   = v_s[g];
			assign sd_i  = sd_s[g];
		end
		always_comb begin
			rem_sh = {r_i, q_i[NW-1]};
			diff   = rem_sh - (NW+1)'(d_i);
			q_n    = {q_i[NW-2:0], ~diff[NW]};
			r_n    = diff[NW] ? rem_sh[NW-1:0] : diff[NW-1:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g+1]   <= q_n;
				r_s[g+1]   <= r_n;
				d_s[g+1]   <= d_i;
				neg_s[g+1] <= neg_i;
				sd_s[g+1]  <= sd_i;
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quo       = neg_s[NW] ? -$signed(q_s[NW]) : $signed(q_s[NW]);
	assign side_out  = sd_s[NW];
endmodule

// ----- sv/vrp_front.sv -----
`timescale 1ns / 1ps
// Rotation, depth translation and gain stages (five register stages).
// Depends on vrp_pkg.
module vrp_front import vrp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  logic signed [31:0]       vx,
	input  logic signed [31:0]       vy,
	input  logic signed [31:0]       vz,
	output logic                     out_valid,
	output logic signed [NUM_W-1:0]  px,
	output logic signed [NUM_W-1:0]  py,
	output logic signed [DEN_W-1:0]  w
);
	// round half away from zero: one add, bias one less for negatives
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
		logic signed [63:0] half;
		half = 64'sd1 <<< (n - 1);
		return (v + (v[63] ? half - 64'sd1 : half)) >>> n;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	// stage 1: roll products
	logic signed [47:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [31:0] z_s1;
	// stage 2: roll sums, rounded
	logic signed [34:0] x1_s2, y1_s2;
	logic signed [31:0] z_s2;
	// stage 3: pitch products
	logic signed [50:0] yc_s3, zs_s3, ys_s3, zc_s3;
	logic signed [34:0] x1_s3;
	// stage 4: pitch sums
	logic signed [34:0] x1_s4;
	logic signed [37:0] y2_s4, z2_s4;
	// stage 5: gains and depth
	logic signed [NUM_W-1:0] px_s5, py_s5;
	logic signed [DEN_W-1:0] w_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= {in_valid, v_s1, v_s2, v_s3, v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1 <= vx * cfg.cos_roll;
			ys_s1 <= vy * cfg.sin_roll;
			xs_s1 <= vx * cfg.sin_roll;
			yc_s1 <= vy * cfg.cos_roll;
			z_s1  <= vz;
			x1_s2 <= 35'(rnd(64'(xc_s1) - 64'(ys_s1), TRIG_FRAC_BITS));
			y1_s2 <= 35'(rnd(64'(xs_s1) + 64'(yc_s1), TRIG_FRAC_BITS));
			z_s2  <= z_s1;
			yc_s3 <= y1_s2 * cfg.cos_pitch;
			zs_s3 <= z_s2 * cfg.sin_pitch;
			ys_s3 <= y1_s2 * cfg.sin_pitch;
			zc_s3 <= z_s2 * cfg.cos_pitch;
			x1_s3 <= x1_s2;
			y2_s4 <= 38'(rnd(64'(yc_s3) - 64'(zs_s3), TRIG_FRAC_BITS));
			z2_s4 <= 38'(rnd(64'(ys_s3) + 64'(zc_s3), TRIG_FRAC_BITS));
			x1_s4 <= x1_s3;
			px_s5 <= NUM_W'(x1_s4) * $signed({1'b0, cfg.gain_h});
			py_s5 <= NUM_W'(y2_s4) * $signed({1'b0, cfg.gain_v});
			w_s5  <= DEN_W'(z2_s4) + (DEN_W'(3) <<< COORD_FRAC_BITS);
		end
	end

	assign out_valid = v_s5;
	assign px = px_s5;
	assign py = py_s5;
	assign w  = w_s5;
endmodule

// ----- sv/vrp_viewport.sv -----
`timescale 1ns / 1ps
// Zero-depth fallback, limiting, viewport scale, rounding and saturation.
// Depends on vrp_pkg.
module vrp_viewport import vrp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [QUO_W-1:0] qx,
	input  logic signed [QUO_W-1:0] qy,
	input  logic signed [NUM_W-1:0] px,
	input  logic signed [NUM_W-1:0] py,
	input  logic                    wz,
	input  logic [12:0]             sw,
	input  logic [12:0]             sh,
	output logic                    out_valid,
	output logic signed [15:0]      sx,
	output logic signed [15:0]      sy,
	output logic                    dz,
	output logic                    clip
);
	localparam logic signed [42:0] LIM = 43'sd1 <<< 40;

	function automatic logic signed [42:0] lim(input logic signed [NUM_W-1:0] v);
		if (v > NUM_W'(LIM)) return LIM;
		if (v < -NUM_W'(LIM)) return -LIM;
		return 43'(v);
	endfunction

	// round half away from zero: one add, bias one less for negatives
	function automatic logic signed [NUM_W-1:0] rnd(input logic signed [NUM_W-1:0] v,
	                                               input int n);
		logic signed [NUM_W-1:0] half;
		half = NUM_W'(1) <<< (n - 1);
		return (v + (v[NUM_W-1] ? half - NUM_W'(1) : half)) >>> n;
	endfunction

	function automatic logic signed [57:0] rnd58(input logic signed [57:0] v);
		logic signed [57:0] half;
		half = 58'sd1 <<< (NDC_FRAC + 1);
		return (v + (v[57] ? half - 58'sd1 : half)) >>> (NDC_FRAC + 2);
	endfunction

	logic v_s1, v_s2, v_s3;
	logic signed [42:0] nx_s1, ny_s1;
	logic [12:0] sw_s1, sh_s1;
	logic dz_s1, dz_s2, dz_s3;
	logic signed [57:0] mx_s2, my_s2;
	logic signed [15:0] sx_s3, sy_s3;
	logic clip_s3;
	logic signed [57:0] rx, ry;
	logic ox, oy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3} <= {in_valid, v_s1, v_s2};
		end
	end

	always_comb begin
		rx = rnd58(mx_s2);
		ry = rnd58(my_s2);
		ox = (rx > 58'sd32767) || (rx < -58'sd32768);
		oy = (ry > 58'sd32767) || (ry < -58'sd32768);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= wz ? lim(rnd(px, COORD_FRAC_BITS)) : lim(qx);
			ny_s1 <= wz ? lim(rnd(py, COORD_FRAC_BITS)) : lim(qy);
			sw_s1 <= sw;
			sh_s1 <= sh;
			dz_s1 <= wz;
			mx_s2 <= (58'(nx_s1) + 58'sd65536) * $signed({45'd0, sw_s1});
			my_s2 <= (58'(ny_s1) + 58'sd65536) * $signed({45'd0, sh_s1});
			dz_s2 <= dz_s1;
			sx_s3 <= rx > 58'sd32767 ? 16'sd32767 : rx < -58'sd32768 ? -16'sd32768 : 16'(rx);
			sy_s3 <= ry > 58'sd32767 ? 16'sd32767 : ry < -58'sd32768 ? -16'sd32768 : 16'(ry);
			clip_s3 <= ox | oy;
			dz_s3 <= dz_s2;
		end
	end

	assign out_valid = v_s3;
	assign sx = sx_s3;
	assign sy = sy_s3;
	assign dz = dz_s3;
	assign clip = clip_s3;
endmodule

// ----- sv/vertex_rotate_project_viewport.sv -----
`timescale 1ns / 1ps
// Channel   | dir | tdata / fields
// s_axis    | in  | vert_x[31:0], vert_y[63:32], vert_z[95:64]
// m_axis    | out | screen_x[15:0], screen_y[31:16]; tuser depth_zero[0], clipped[1]
// cfg       | in  | cfg_index[2:0], cfg_data[31:0]
// One word per cycle sustained while m_axis is not stalled; words pass through front, divider and viewport.
// The divider, one quotient bit per stage, sets the depth of the pipeline.
// Reset clears all valid bits and loads the register defaults.
// A stall on m_axis freezes every stage; the output register holds its word.
`include "vertex_rotate_project_viewport_defines.svh"
module vertex_rotate_project_viewport import vrp_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // vert_x, vert_y, vert_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // screen_x, screen_y
	output logic [1:0]  m_axis_tuser,  // depth_zero, clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	cfg_t cfg_q;
	logic en;
	logic fv;
	logic signed [NUM_W-1:0] px, py;
	logic signed [DEN_W-1:0] w;
	logic dv, dv_y;
	logic signed [QUO_W-1:0] qx, qy;
	logic [NUM_W-1:0] px_d;
	logic [NUM_W:0] py_d;
	logic vv;
	logic signed [15:0] sx, sy;
	logic dz, clip;
	logic out_stall;
	logic [33:0] out_word;

	// whole pipeline advances unless the output word is held
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
			           24'd65536, 24'd65536, 13'd320, 13'd240};
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_COS_ROLL:  cfg_q.cos_roll  <= cfg_data[15:0];
				REG_SIN_ROLL:  cfg_q.sin_roll  <= cfg_data[15:0];
				REG_COS_PITCH: cfg_q.cos_pitch <= cfg_data[15:0];
				REG_SIN_PITCH: cfg_q.sin_pitch <= cfg_data[15:0];
				REG_GAIN_H:    cfg_q.gain_h    <= cfg_data[23:0];
				REG_GAIN_V:    cfg_q.gain_v    <= cfg_data[23:0];
				REG_SCREEN_W:  cfg_q.screen_w  <= cfg_data[12:0];
				REG_SCREEN_H:  cfg_q.screen_h  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	vrp_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.vx(s_axis_tdata[31:0]), .vy(s_axis_tdata[63:32]), .vz(s_axis_tdata[95:64]),
		.out_valid(fv), .px, .py, .w
	);

	// each numerator rides alongside its own divider; the zero flag goes with y
	vrp_divider #(.NW(NUM_W), .DW(DEN_W), .SW(NUM_W)) u_div_x (
		.clk, .arst_n, .en, .in_valid(fv), .num(px), .den(w), .side_in(px),
		.out_valid(dv), .quo(qx), .side_out(px_d)
	);

	vrp_divider #(.NW(NUM_W), .DW(DEN_W), .SW(NUM_W+1)) u_div_y (
		.clk, .arst_n, .en, .in_valid(fv), .num(py), .den(w), .side_in({w == '0, py}),
		.out_valid(dv_y), .quo(qy), .side_out(py_d)
	);

	vrp_viewport #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_vp (
		.clk, .arst_n, .en, .in_valid(dv), .qx, .qy,
		.px(px_d), .py(py_d[NUM_W-1:0]), .wz(py_d[NUM_W]),
		.sw(cfg_q.screen_w), .sh(cfg_q.screen_h),
		.out_valid(vv), .sx, .sy, .dz, .clip
	);

	assign m_axis_tvalid = vv;
	assign m_axis_tdata  = {sy, sx};
	assign m_axis_tuser  = {clip, dz};

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tuser, m_axis_tdata};

	`VRP_ASSERT_NEXT(a_hold, clk, arst_n, out_stall, $stable(out_word) && vv, "word not held")
	`VRP_ASSERT(a_ready, clk, arst_n, s_axis_tready == en, "input ready not tied to stall")
	`VRP_ASSERT(a_lanes, clk, arst_n, dv == dv_y, "divider lanes out of step")
endmodule
